/* hw/rtl/indexed_min_heap_open_list_core_assert.svh */
// Assertion macros used by the open list sequencer.
`ifndef INDEXED_MIN_HEAP_OPEN_LIST_CORE_ASSERT_SVH
`define INDEXED_MIN_HEAP_OPEN_LIST_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IMH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("open list assertion failed");
`define IMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("open list assertion failed");
`else
`define IMH_ASSERT_IMPLY(label, ante, cons)
`define IMH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/imh_pkg.sv */
// Types, constants and codes of the open list.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
    localparam int ID_W       = 16;
    localparam int COST_W     = 24;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;
    localparam int OCC_W      = 10;
    localparam int HEAP_SLOTS = 1024;
    localparam int GRID_CELLS = 65536;
    localparam int POS_W      = $clog2(HEAP_SLOTS);
    localparam int CELL_SPACE = 2 ** ID_W;
    localparam int HEAP_W     = COST_W + ID_W;
    localparam int REC_W      = ID_W + 2 * COST_W;
    localparam int SLOT_W     = POS_W + 1;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

    typedef struct packed {
        logic [COST_W-1:0] f;
        logic [ID_W-1:0]   id;
    } heap_ent_t;

    typedef struct packed {
        logic [ID_W-1:0]   parent;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] f;
    } rec_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } slot_ent_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   cell_id;
        logic [ID_W-1:0]   parent_id;
        logic [COST_W-1:0] cost_g;
        logic [COST_W-1:0] cost_f;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [ID_W-1:0]   res_cell_id;
        logic [ID_W-1:0]   res_parent_id;
        logic [COST_W-1:0] res_cost_g;
        logic [COST_W-1:0] res_cost_f;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

    function automatic logic in_grid(input logic [ID_W-1:0] id);
        return 32'(id) < 32'(GRID_CELLS);
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/imh_req_if.sv */
// Request and result channel interfaces of the open list.
`timescale 1ns / 1ps
`default_nettype none
interface imh_req_if;
    import imh_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   cell_id;
    logic [ID_W-1:0]   parent_id;
    logic [COST_W-1:0] cost_g;
    logic [COST_W-1:0] cost_f;
    modport source (output valid, cmd, cell_id, parent_id, cost_g, cost_f, input ready);
    modport sink (input valid, cmd, cell_id, parent_id, cost_g, cost_f, output ready);
endinterface

interface imh_res_if;
    import imh_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [ID_W-1:0]   res_cell_id;
    logic [ID_W-1:0]   res_parent_id;
    logic [COST_W-1:0] res_cost_g;
    logic [COST_W-1:0] res_cost_f;
    logic [OCC_W-1:0]  occupancy;
    modport source (output valid, status, found, res_cell_id, res_parent_id, res_cost_g,
                    res_cost_f, occupancy, input ready);
    modport sink (input valid, status, found, res_cell_id, res_parent_id, res_cost_g,
                  res_cost_f, occupancy, output ready);
endinterface
`default_nettype wire

/* hw/rtl/imh_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/imh_seq.sv */
// Command sequencer with the heap, record and slot memories.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_open_list_core_assert.svh"
module imh_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  imh_pkg::req_t req_data,
    output logic          idle,
    output logic          done,
    input  logic          take,
    output imh_pkg::res_t result
);
    import imh_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_POP1 = 4'd3;
    localparam logic [3:0] S_POP2 = 4'd4;
    localparam logic [3:0] S_REM  = 4'd5;
    localparam logic [3:0] S_MV   = 4'd6;
    localparam logic [3:0] S_DN0  = 4'd7;
    localparam logic [3:0] S_DN1  = 4'd8;
    localparam logic [3:0] S_DN2  = 4'd9;
    localparam logic [3:0] S_DN3  = 4'd10;
    localparam logic [3:0] S_DNE  = 4'd11;
    localparam logic [3:0] S_INS  = 4'd12;
    localparam logic [3:0] S_UP0  = 4'd13;
    localparam logic [3:0] S_UP1  = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

    logic [3:0]        st_reg, st_next;
    logic [ID_W-1:0]   clr_reg, clr_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic              ins_reg, ins_next;
    req_t              rq_reg, rq_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  hole_reg, hole_next;
    heap_ent_t         mv_reg, mv_next;
    heap_ent_t         best_reg, best_next;
    logic [POS_W-1:0]  bpos_reg, bpos_next;
    res_t              rs_reg, rs_next;

    logic              heap_rd_en, heap_wr_en;
    logic [POS_W-1:0]  heap_rd_addr, heap_wr_addr;
    logic [HEAP_W-1:0] heap_rd_data, heap_wr_data;
    logic              rec_rd_en, rec_wr_en;
    logic [ID_W-1:0]   rec_rd_addr, rec_wr_addr;
    logic [REC_W-1:0]  rec_rd_data, rec_wr_data;
    logic              slot_rd_en, slot_wr_en;
    logic [ID_W-1:0]   slot_rd_addr, slot_wr_addr;
    logic [SLOT_W-1:0] slot_rd_data, slot_wr_data;

    heap_ent_t         hrd;
    rec_t              rrd;
    slot_ent_t         srd;
    logic              present;
    logic [POS_W:0]    c_idx, c1_idx, cnt_ext;
    logic [POS_W-1:0]  par_pos, cnt_dec;
    logic [3:0]        end_st;

    assign hrd     = heap_rd_data;
    assign rrd     = rec_rd_data;
    assign srd     = slot_rd_data;
    assign present = in_grid(rq_reg.cell_id) && srd.valid;
    assign c_idx   = {pos_reg, 1'b1};
    assign c1_idx  = c_idx + 1'b1;
    assign cnt_ext = {1'b0, cnt_reg};
    assign par_pos = (pos_reg - 1'b1) >> 1;
    assign cnt_dec = cnt_reg - 1'b1;
    assign end_st  = ins_reg ? S_INS : S_DONE;

    imh_ram #(.WIDTH(HEAP_W), .DEPTH(HEAP_SLOTS)) u_heap (
        .clk(clk), .rd_en(heap_rd_en), .rd_addr(heap_rd_addr), .rd_data(heap_rd_data),
        .wr_en(heap_wr_en), .wr_addr(heap_wr_addr), .wr_data(heap_wr_data)
    );
    imh_ram #(.WIDTH(REC_W), .DEPTH(CELL_SPACE)) u_rec (
        .clk(clk), .rd_en(rec_rd_en), .rd_addr(rec_rd_addr), .rd_data(rec_rd_data),
        .wr_en(rec_wr_en), .wr_addr(rec_wr_addr), .wr_data(rec_wr_data)
    );
    imh_ram #(.WIDTH(SLOT_W), .DEPTH(CELL_SPACE)) u_slot (
        .clk(clk), .rd_en(slot_rd_en), .rd_addr(slot_rd_addr), .rd_data(slot_rd_data),
        .wr_en(slot_wr_en), .wr_addr(slot_wr_addr), .wr_data(slot_wr_data)
    );

    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        cnt_next  = cnt_reg;
        ins_next  = ins_reg;
        rq_next   = rq_reg;
        id_next   = id_reg;
        pos_next  = pos_reg;
        hole_next = hole_reg;
        mv_next   = mv_reg;
        best_next = best_reg;
        bpos_next = bpos_reg;
        rs_next   = rs_reg;
        heap_rd_en = 1'b0; heap_rd_addr = '0;
        heap_wr_en = 1'b0; heap_wr_addr = '0; heap_wr_data = '0;
        rec_rd_en  = 1'b0; rec_rd_addr  = '0;
        rec_wr_en  = 1'b0; rec_wr_addr  = '0; rec_wr_data  = '0;
        slot_rd_en = 1'b0; slot_rd_addr = '0;
        slot_wr_en = 1'b0; slot_wr_addr = '0; slot_wr_data = '0;
        unique case (st_reg)
            S_CLR:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    cnt_next = '0;
                    st_next  = ins_reg ? S_DONE : S_IDLE;
                    ins_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    rq_next = req_data;
                    id_next = req_data.cell_id;
                    rs_next = '0;
                    unique case (req_data.cmd)
                        CMD_CLEAR:
                        begin
                            clr_next = '0;
                            ins_next = 1'b1;
                            st_next  = S_CLR;
                        end
                        CMD_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rs_next.status = STAT_EMPTY;
                                st_next = S_DONE;
                            end
                            else
                            begin
                                heap_rd_en = 1'b1;
                                st_next    = S_POP1;
                            end
                        end
                        CMD_PUSH, CMD_REMOVE, CMD_LOOKUP:
                        begin
                            slot_rd_en   = 1'b1;
                            slot_rd_addr = req_data.cell_id;
                            rec_rd_en    = 1'b1;
                            rec_rd_addr  = req_data.cell_id;
                            st_next      = S_CHK;
                        end
                        default:
                        begin
                            st_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CHK:
            begin
                hole_next = srd.pos;
                ins_next  = 1'b0;
                st_next   = S_DONE;
                unique case (rq_reg.cmd)
                    CMD_LOOKUP:
                    begin
                        if (present)
                        begin
                            rs_next.found         = 1'b1;
                            rs_next.res_cell_id   = rq_reg.cell_id;
                            rs_next.res_parent_id = rrd.parent;
                            rs_next.res_cost_g    = rrd.g;
                            rs_next.res_cost_f    = rrd.f;
                        end
                        else
                        begin
                            rs_next.status = STAT_ABSENT;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (present)
                        begin
                            st_next = S_REM;
                        end
                        else
                        begin
                            rs_next.status = STAT_ABSENT;
                        end
                    end
                    default:
                    begin
                        priority if (!in_grid(rq_reg.cell_id))
                        begin
                            rs_next.status = STAT_ABSENT;
                        end
                        else if (present)
                        begin
                            if (rq_reg.cost_g < rrd.g)
                            begin
                                ins_next = 1'b1;
                                st_next  = S_REM;
                            end
                        end
                        else if (32'(cnt_reg) >= 32'(HEAP_SLOTS - 1))
                        begin
                            rs_next.status = STAT_FULL;
                        end
                        else
                        begin
                            st_next = S_INS;
                        end
                    end
                endcase
            end
            S_POP1:
            begin
                id_next     = hrd.id;
                rec_rd_en   = 1'b1;
                rec_rd_addr = hrd.id;
                st_next     = S_POP2;
            end
            S_POP2:
            begin
                rs_next.found         = 1'b1;
                rs_next.res_cell_id   = id_reg;
                rs_next.res_parent_id = rrd.parent;
                rs_next.res_cost_g    = rrd.g;
                rs_next.res_cost_f    = rrd.f;
                hole_next = '0;
                ins_next  = 1'b0;
                st_next   = S_REM;
            end
            S_REM:
            begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = id_reg;
                cnt_next     = cnt_dec;
                pos_next     = hole_reg;
                if (hole_reg >= cnt_dec)
                begin
                    st_next = end_st;
                end
                else
                begin
                    heap_rd_en   = 1'b1;
                    heap_rd_addr = cnt_dec;
                    st_next      = S_MV;
                end
            end
            S_MV:
            begin
                mv_next = hrd;
                st_next = S_DN0;
            end
            S_DN0:
            begin
                if (c_idx < cnt_ext)
                begin
                    heap_rd_en   = 1'b1;
                    heap_rd_addr = c_idx[POS_W-1:0];
                    st_next      = S_DN1;
                end
                else
                begin
                    st_next = S_DNE;
                end
            end
            S_DN1:
            begin
                best_next = hrd;
                bpos_next = c_idx[POS_W-1:0];
                if (c1_idx < cnt_ext)
                begin
                    heap_rd_en   = 1'b1;
                    heap_rd_addr = c1_idx[POS_W-1:0];
                    st_next      = S_DN2;
                end
                else
                begin
                    st_next = S_DN3;
                end
            end
            S_DN2:
            begin
                if (hrd.f < best_reg.f)
                begin
                    best_next = hrd;
                    bpos_next = c1_idx[POS_W-1:0];
                end
                st_next = S_DN3;
            end
            S_DN3:
            begin
                if (best_reg.f < mv_reg.f)
                begin
                    heap_wr_en   = 1'b1;
                    heap_wr_addr = pos_reg;
                    heap_wr_data = best_reg;
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = best_reg.id;
                    slot_wr_data = {1'b1, pos_reg};
                    pos_next     = bpos_reg;
                    st_next      = S_DN0;
                end
                else
                begin
                    st_next = S_DNE;
                end
            end
            S_DNE:
            begin
                if (pos_reg == hole_reg)
                begin
                    st_next = S_UP0;
                end
                else
                begin
                    heap_wr_en   = 1'b1;
                    heap_wr_addr = pos_reg;
                    heap_wr_data = mv_reg;
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = mv_reg.id;
                    slot_wr_data = {1'b1, pos_reg};
                    st_next      = end_st;
                end
            end
            S_INS:
            begin
                rec_wr_en   = 1'b1;
                rec_wr_addr = rq_reg.cell_id;
                rec_wr_data = {rq_reg.parent_id, rq_reg.cost_g, rq_reg.cost_f};
                mv_next     = {rq_reg.cost_f, rq_reg.cell_id};
                pos_next    = cnt_reg;
                cnt_next    = cnt_reg + 1'b1;
                ins_next    = 1'b0;
                st_next     = S_UP0;
            end
            S_UP0:
            begin
                if (pos_reg == '0)
                begin
                    heap_wr_en   = 1'b1;
                    heap_wr_addr = pos_reg;
                    heap_wr_data = mv_reg;
                    slot_wr_en   = 1'b1;
                    slot_wr_addr = mv_reg.id;
                    slot_wr_data = {1'b1, pos_reg};
                    st_next      = end_st;
                end
                else
                begin
                    heap_rd_en   = 1'b1;
                    heap_rd_addr = par_pos;
                    st_next      = S_UP1;
                end
            end
            S_UP1:
            begin
                heap_wr_en   = 1'b1;
                heap_wr_addr = pos_reg;
                slot_wr_en   = 1'b1;
                slot_wr_data = {1'b1, pos_reg};
                if (mv_reg.f < hrd.f)
                begin
                    heap_wr_data = hrd;
                    slot_wr_addr = hrd.id;
                    pos_next     = par_pos;
                    st_next      = S_UP0;
                end
                else
                begin
                    heap_wr_data = mv_reg;
                    slot_wr_addr = mv_reg.id;
                    st_next      = end_st;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLR;
            clr_reg <= '0;
            cnt_reg <= '0;
            ins_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
            ins_reg <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg   <= rq_next;
        id_reg   <= id_next;
        pos_reg  <= pos_next;
        hole_reg <= hole_next;
        mv_reg   <= mv_next;
        best_reg <= best_next;
        bpos_reg <= bpos_next;
        rs_reg   <= rs_next;
    end

    assign idle = (st_reg == S_IDLE);
    assign done = (st_reg == S_DONE);

    always_comb
    begin
        result           = rs_reg;
        result.occupancy = OCC_W'(cnt_reg);
    end

    `IMH_ASSERT_IMPLY(a_cnt_cap, 1'b1, 32'(cnt_reg) <= 32'(HEAP_SLOTS - 1))
    `IMH_ASSERT_IMPLY(a_start_idle, start, st_reg == S_IDLE)
    `IMH_ASSERT_IMPLY(a_pop_found, done && rq_reg.cmd == CMD_POP && rs_reg.status == STAT_OK, rs_reg.found)
    `IMH_ASSERT_NEXT(a_done_hold, done && !take, done)
endmodule
`default_nettype wire

/* hw/rtl/indexed_min_heap_open_list_core.sv */
// Top level of the indexed min-heap open list with its result register.
`timescale 1ns / 1ps
`default_nettype none
// Indexed binary min-heap open list: one result per request. The heap keys
// and ids, the per-cell records and the per-cell heap positions live in three
// synchronous RAMs with one read and one write port each, so a request runs
// as a sequence of read-then-decide steps. A pop or a remove whose entry is
// not the last one moves the last entry into the hole, where it sinks or
// rises to its place. A replacing push is a remove followed by a push. Clear,
// and reset itself, sweep the 65536-entry position RAM one entry per cycle,
// and no request is taken until the sweep ends. A finished result waits in an
// output register while the next request is taken.
module indexed_min_heap_open_list_core (
    input  logic   clk,
    input  logic   rst_n,
    imh_req_if.sink   req,
    imh_res_if.source res
);
    import imh_pkg::*;

    logic   seq_idle, seq_done, load;
    req_t   req_data;
    res_t   seq_res;
    logic   out_valid_reg, out_valid_next;
    res_t   out_data_reg;

    assign req_data  = {req.cmd, req.cell_id, req.parent_id, req.cost_g, req.cost_f};
    assign req.ready = seq_idle;
    assign load      = seq_done && (!out_valid_reg || res.ready);

    imh_seq u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .start(req.valid && seq_idle),
        .req_data(req_data),
        .idle(seq_idle),
        .done(seq_done),
        .take(load),
        .result(seq_res)
    );

    assign out_valid_next = load || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= seq_res;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_data_reg.status;
    assign res.found         = out_data_reg.found;
    assign res.res_cell_id   = out_data_reg.res_cell_id;
    assign res.res_parent_id = out_data_reg.res_parent_id;
    assign res.res_cost_g    = out_data_reg.res_cost_g;
    assign res.res_cost_f    = out_data_reg.res_cost_f;
    assign res.occupancy     = out_data_reg.occupancy;
endmodule
`default_nettype wire
